/* hw/rtl/utt_pkg.sv */
package utt_pkg;

    // One input word: a UTF-8 byte or the end marker
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } t_in_word;

    // One output word: a UTF-16 code unit
    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_of_run;
    } t_out_word;

    // Decoder state carried between bytes
    typedef struct packed {
        logic [20:0] partial_code;
        logic [1:0]  bytes_remaining;
        logic [1:0]  bytes_held;
    } t_dec_state;

    localparam int MAX_UNITS = 4;
    localparam int CNT_W     = $clog2(MAX_UNITS + 1);

    // Units produced by one input byte, from the decoder to the output buffer
    typedef struct packed {
        logic [MAX_UNITS-1:0][15:0] units;
        logic [CNT_W-1:0]           cnt;
    } t_unit_group;

    localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
    localparam logic [15:0] SURR_HIGH    = 16'hD800;
    localparam logic [15:0] SURR_LOW     = 16'hDC00;
    localparam logic [20:0] SUPP_OFFSET  = 21'h10000;

endpackage

/* hw/rtl/utt_decode.sv */
module utt_decode
    import utt_pkg::*;
(
    input  t_dec_state  i_state,
    input  t_in_word    i_word,
    output t_dec_state  o_state,
    output t_unit_group o_group
);

    logic [7:0]  c;
    logic        is_cont;
    logic        open_seq;
    logic [2:0]  n_flush;
    logic [20:0] cp;
    logic [20:0] v;
    logic [15:0] new_unit0;
    logic [15:0] new_unit1;
    logic [1:0]  new_cnt;

    assign c        = i_word.data_byte;
    assign is_cont  = (c[7:6] == 2'b10);
    assign open_seq = (i_state.bytes_remaining != 2'd0);

    // code point finished by a continuation byte, split into a pair above the BMP
    assign cp = {i_state.partial_code[14:0], c[5:0]};
    assign v  = cp - SUPP_OFFSET;

    always_comb begin
        o_state   = i_state;
        n_flush   = 3'd0;
        new_unit0 = REPL_UNIT;
        new_unit1 = REPL_UNIT;
        new_cnt   = 2'd0;

        if (i_word.end_of_string) begin
            if (open_seq) begin
                n_flush = 3'd1 + {1'b0, i_state.bytes_held};
            end
            o_state = '0;
        end else if (open_seq && is_cont) begin
            o_state.partial_code    = cp;
            o_state.bytes_remaining = i_state.bytes_remaining - 2'd1;
            o_state.bytes_held      = i_state.bytes_held + 2'd1;
            if (i_state.bytes_remaining == 2'd1) begin
                o_state = '0;
                if (|cp[20:16]) begin
                    new_unit0 = SURR_HIGH + {5'd0, v[20:10]};
                    new_unit1 = SURR_LOW + {6'd0, v[9:0]};
                    new_cnt   = 2'd2;
                end else begin
                    new_unit0 = cp[15:0];
                    new_cnt   = 2'd1;
                end
            end
        end else begin
            // broken sequence: one replacement for the lead and each held byte
            if (open_seq) begin
                n_flush = 3'd1 + {1'b0, i_state.bytes_held};
            end
            o_state = '0;
            if (c[7] == 1'b0) begin
                new_unit0 = {8'd0, c};
                new_cnt   = 2'd1;
            end else if (c[7:5] == 3'b110) begin
                o_state.partial_code    = {16'd0, c[4:0]};
                o_state.bytes_remaining = 2'd1;
            end else if (c[7:4] == 4'b1110) begin
                o_state.partial_code    = {17'd0, c[3:0]};
                o_state.bytes_remaining = 2'd2;
            end else if (c[7:3] == 5'b11110) begin
                o_state.partial_code    = {18'd0, c[2:0]};
                o_state.bytes_remaining = 2'd3;
            end else begin
                new_cnt = 2'd1;
            end
        end
    end

    // replacements first, then the units of the new byte
    always_comb begin
        for (int i = 0; i < MAX_UNITS; i++) begin
            if (i < int'(n_flush)) begin
                o_group.units[i] = REPL_UNIT;
            end else if (i == int'(n_flush)) begin
                o_group.units[i] = new_unit0;
            end else begin
                o_group.units[i] = new_unit1;
            end
        end
        o_group.cnt = n_flush + {1'b0, new_cnt};
    end

endmodule

/* hw/rtl/utt_outbuf.sv */
module utt_outbuf
    import utt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_unit_group i_group,
    output logic        o_room,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_word   o_word
);

    logic [MAX_UNITS-1:0][15:0] r_units;
    logic [CNT_W-1:0]           r_cnt;
    logic                       take;

    assign take    = o_valid && !i_stall;
    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && !i_stall);

    assign o_word.code_unit   = r_units[0];
    assign o_word.last_of_run = (r_cnt == CNT_W'(1));

    // count of words still held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_group.cnt;
        end else if (take) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // unit shift line, head is the word on the port
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_units <= i_group.units;
        end else if (take) begin
            for (int i = 0; i < MAX_UNITS - 1; i++) begin
                r_units[i] <= r_units[i+1];
            end
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_UNITS))
        else $error("output buffer count out of range");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && (r_cnt > CNT_W'(1)) |=> o_valid && (r_cnt == $past(r_cnt) - CNT_W'(1)))
        else $error("run dropped before its last word");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && (r_cnt == $past(r_cnt)))
        else $error("stalled run changed");

endmodule

/* hw/rtl/utf8_to_utf16_transcoder.sv */
// UTF-8 to UTF-16 transcoder.
// Input channel: i_in_valid / o_in_stall carry one word per byte; a word with
// end_of_string set flushes any open sequence and its data_byte is ignored.
// Output channel: o_out_valid / i_out_stall carry one UTF-16 code unit per
// word; last_of_run marks the final unit caused by one input word.
// Each input byte is decoded in the cycle it is accepted and its units (zero
// to four) land in the output buffer, so the first unit is valid in the
// cycle after acceptance. The buffer sends one unit a cycle while the
// receiver does not stall; a new byte is taken while the buffer is empty or
// its last unit leaves: without stalls, bytes giving at most one unit go
// through at one per cycle; more units hold the input until the last leaves.
// Reset (synchronous, active low) clears the open sequence and empties the
// buffer. When the receiver stalls, the head unit holds and the input stalls
// once the buffer has no room.
module utf8_to_utf16_transcoder
    import utt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);

    t_dec_state  r_state;
    t_dec_state  n_state;
    t_unit_group group;
    logic        room;
    logic        accept;

    assign o_in_stall = !room;
    assign accept     = i_in_valid && room;

    utt_decode u_decode (
        .i_state (r_state),
        .i_word  (i_in_data),
        .o_state (n_state),
        .o_group (group)
    );

    utt_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_group (group),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_data)
    );

    // sequence state advances with each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.bytes_remaining != 2'd0) |->
            ({1'b0, r_state.bytes_remaining} + {1'b0, r_state.bytes_held} <= 3'd3))
        else $error("held and remaining bytes exceed a sequence");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.bytes_remaining == 2'd0) |->
            (r_state.partial_code == '0) && (r_state.bytes_held == 2'd0))
        else $error("stale partial code with no open sequence");

    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_data.end_of_string |=> (r_state.bytes_remaining == 2'd0))
        else $error("end marker left a sequence open");

endmodule

/* bench/tb_utf8_to_utf16_transcoder.sv */
`timescale 1ns / 1ps

module tb_utf8_to_utf16_transcoder;
    import utt_pkg::*;

    localparam int unsigned RANDOM_WORDS    = 500;
    localparam int unsigned MAX_BURST       = 24;
    localparam int unsigned MAX_GAP         = 6;
    localparam int unsigned HOLD_OFF_CYCLES = 150;
    localparam int unsigned HOLD_OFF_AFTER  = 80;
    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES    = 20;

    // One stimulus word; typed rows carry their code units written out by hand
    typedef struct packed {
        t_in_word             word;
        logic                 typed;
        logic [2:0]           n_units;
        logic [0:3][15:0]     units;
    } t_stim_row;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_EVERY_THIRD,
        STALL_HEAVY
    } t_stall_mode;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_data;

    // Decoder state of the prediction and the code units still owed by the DUT
    t_dec_state  model_state = '0;
    logic [15:0] step_units[$];
    t_out_word   pending_units[$];
    t_stim_row   stim_rows[$];
    t_stim_row   offered_row = '0;

    int unsigned error_count     = 0;
    int unsigned words_accepted  = 0;
    int unsigned end_markers     = 0;
    int unsigned units_checked   = 0;
    int unsigned surrogate_units = 0;
    int unsigned idle_cycles     = 0;

    utf8_to_utf16_transcoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_stim_row make_row(logic [7:0] b, logic eos, logic typed,
                                           logic [2:0] n, logic [0:3][15:0] units);
        t_stim_row row;
        row.word.data_byte     = b;
        row.word.end_of_string = eos;
        row.typed              = typed;
        row.n_units            = n;
        row.units              = units;
        return row;
    endfunction

    // ---------------------------------------------------------------
    // Prediction: one input word in, up to four code units out
    // ---------------------------------------------------------------
    function automatic void add_unit(logic [15:0] unit);
        if (step_units.size() < MAX_UNITS) begin
            step_units.push_back(unit);
        end
    endfunction

    // Replacement for the lead byte plus one per continuation held so far
    function automatic void flush_open_sequence();
        if (model_state.bytes_remaining != 2'd0) begin
            add_unit(REPL_UNIT);
            for (int i = 0; i < int'(model_state.bytes_held); i++) begin
                add_unit(REPL_UNIT);
            end
            model_state = '0;
        end
    endfunction

    function automatic void decode_utf8_word(t_in_word w);
        logic [7:0]  b;
        logic [20:0] offset_cp;
        b = w.data_byte;
        step_units.delete();
        if (w.end_of_string) begin
            flush_open_sequence();
        end else if (model_state.bytes_remaining != 2'd0 && b[7:6] == 2'b10) begin
            // continuation: six more bits, 21-bit accumulator
            model_state.partial_code    = {model_state.partial_code[14:0], b[5:0]};
            model_state.bytes_remaining = model_state.bytes_remaining - 2'd1;
            model_state.bytes_held      = model_state.bytes_held + 2'd1;
            if (model_state.bytes_remaining == 2'd0) begin
                if (model_state.partial_code <= 21'h00FFFF) begin
                    add_unit(model_state.partial_code[15:0]);
                end else begin
                    // surrogate pair, also past 0x10FFFF
                    offset_cp = model_state.partial_code - SUPP_OFFSET;
                    add_unit(SURR_HIGH + {5'b0, offset_cp[20:10]});
                    add_unit(SURR_LOW + {6'b0, offset_cp[9:0]});
                end
                model_state = '0;
            end
        end else begin
            // anything else closes an open sequence, then decodes fresh
            flush_open_sequence();
            if (!b[7]) begin
                add_unit({8'h00, b});
            end else if (b[7:5] == 3'b110) begin
                model_state.partial_code    = {16'b0, b[4:0]};
                model_state.bytes_remaining = 2'd1;
                model_state.bytes_held      = 2'd0;
            end else if (b[7:4] == 4'b1110) begin
                model_state.partial_code    = {17'b0, b[3:0]};
                model_state.bytes_remaining = 2'd2;
                model_state.bytes_held      = 2'd0;
            end else if (b[7:3] == 5'b11110) begin
                model_state.partial_code    = {18'b0, b[2:0]};
                model_state.bytes_remaining = 2'd3;
                model_state.bytes_held      = 2'd0;
            end else begin
                add_unit(REPL_UNIT);
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // Random text: mostly well-formed characters, some damage and noise
    // ---------------------------------------------------------------
    task automatic append_random_text(input int unsigned target);
        int unsigned pick;
        int unsigned seq_len;
        int unsigned n_cont;
        logic [7:0]  lead;
        while (stim_rows.size() < target) begin
            pick    = $urandom_range(0, 99);
            seq_len = (pick < 62) ? $urandom_range(1, 4) : $urandom_range(2, 4);
            case (seq_len)
                1: lead = 8'($urandom_range(8'h00, 8'h7F));
                2: lead = 8'($urandom_range(8'hC0, 8'hDF));
                3: lead = 8'($urandom_range(8'hE0, 8'hEF));
                default: lead = 8'($urandom_range(8'hF0, 8'hF7));
            endcase
            if (pick < 74) begin
                // complete character, or one cut short before its last byte
                n_cont = (pick < 62) ? seq_len - 1 : $urandom_range(0, seq_len - 2);
                stim_rows.push_back(make_row(lead, 1'b0, 1'b0, 3'd0, '0));
                for (int k = 0; k < int'(n_cont); k++) begin
                    stim_rows.push_back(make_row({2'b10, 6'($urandom)}, 1'b0, 1'b0, 3'd0,
                                                 '0));
                end
                if (pick >= 62 && $urandom_range(0, 2) == 0) begin
                    stim_rows.push_back(make_row(8'($urandom), 1'b1, 1'b0, 3'd0, '0));
                end
            end else if (pick < 82) begin
                stim_rows.push_back(make_row(8'($urandom), 1'b1, 1'b0, 3'd0, '0));
            end else if (pick < 91) begin
                stim_rows.push_back(make_row({2'b10, 6'($urandom)}, 1'b0, 1'b0, 3'd0, '0));
            end else begin
                stim_rows.push_back(make_row(8'($urandom_range(8'hF8, 8'hFF)), 1'b0, 1'b0,
                                             3'd0, '0));
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Monitor: check delivered words, predict accepted ones, watchdog
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_out_word exp_word;
        logic      in_fire;
        logic      out_fire;
        in_fire  = i_in_valid && !o_in_stall;
        out_fire = o_out_valid && !i_out_stall;
        if (i_rst_n) begin
            if (out_fire) begin
                units_checked++;
                if (pending_units.size() == 0) begin
                    $error("unexpected code unit %h (last_of_run %b)",
                           o_out_data.code_unit, o_out_data.last_of_run);
                    error_count++;
                end else begin
                    exp_word = pending_units.pop_front();
                    if (exp_word.code_unit[15:10] == 6'b110110) begin
                        surrogate_units++;
                    end
                    if (o_out_data.code_unit !== exp_word.code_unit) begin
                        $error("code_unit: expected %h, actual %h",
                               exp_word.code_unit, o_out_data.code_unit);
                        error_count++;
                    end
                    if (o_out_data.last_of_run !== exp_word.last_of_run) begin
                        $error("last_of_run: expected %b, actual %b",
                               exp_word.last_of_run, o_out_data.last_of_run);
                        error_count++;
                    end
                end
            end

            if (in_fire) begin
                words_accepted++;
                if (offered_row.word.end_of_string) begin
                    end_markers++;
                end
                decode_utf8_word(offered_row.word);
                // hand-written rows replace the predicted units
                if (offered_row.typed) begin
                    step_units.delete();
                    for (int i = 0; i < int'(offered_row.n_units); i++) begin
                        step_units.push_back(offered_row.units[i]);
                    end
                end
                for (int i = 0; i < step_units.size(); i++) begin
                    exp_word.code_unit   = step_units[i];
                    exp_word.last_of_run = (i == step_units.size() - 1);
                    pending_units.push_back(exp_word);
                end
            end
        end

        if (in_fire || out_fire) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("watchdog: no handshake for %0d cycles, %0d units owed",
                   idle_cycles, pending_units.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Receiver: stall modes of random length, one long hold-off
    // ---------------------------------------------------------------
    initial begin : receiver
        t_stall_mode mode;
        int unsigned mode_left;
        int unsigned phase;
        bit          held_off;
        mode      = STALL_NONE;
        mode_left = 0;
        phase     = 0;
        held_off  = 1'b0;
        @(posedge i_rst_n);
        forever begin
            // fill the DUT while the sender keeps offering
            if (!held_off && words_accepted >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                for (int n = 0; n < int'(HOLD_OFF_CYCLES); n++) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end
            if (mode_left == 0) begin
                mode      = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            phase++;
            @(negedge i_clk);
            case (mode)
                STALL_NONE:        i_out_stall <= 1'b0;
                STALL_COIN:        i_out_stall <= ($urandom_range(0, 1) == 0);
                STALL_EVERY_THIRD: i_out_stall <= (phase % 3 == 0);
                STALL_HEAVY:       i_out_stall <= ($urandom_range(0, 4) != 0);
                default:           i_out_stall <= 1'b0;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stimulus, sender and end of run
    // ---------------------------------------------------------------
    initial begin : stimulus
        t_stim_row   row;
        int unsigned burst_left;
        int unsigned gap;
        int unsigned directed_count;

        // directed words: extremes, stray bytes, broken and flushed sequences
        stim_rows.push_back(make_row(8'h00, 1'b0, 1'b1, 3'd1, {16'h0000, 48'h0}));
        stim_rows.push_back(make_row(8'h7F, 1'b0, 1'b1, 3'd1, {16'h007F, 48'h0}));
        stim_rows.push_back(make_row(8'h00, 1'b1, 1'b1, 3'd0, '0));
        stim_rows.push_back(make_row(8'h80, 1'b0, 1'b1, 3'd1, {REPL_UNIT, 48'h0}));
        stim_rows.push_back(make_row(8'hFF, 1'b0, 1'b1, 3'd1, {REPL_UNIT, 48'h0}));
        stim_rows.push_back(make_row(8'hF8, 1'b0, 1'b1, 3'd1, {REPL_UNIT, 48'h0}));
        stim_rows.push_back(make_row(8'hC3, 1'b0, 1'b0, 3'd0, '0));
        stim_rows.push_back(make_row(8'hA9, 1'b0, 1'b0, 3'd0, '0));
        stim_rows.push_back(make_row(8'hE2, 1'b0, 1'b0, 3'd0, '0));
        stim_rows.push_back(make_row(8'h82, 1'b0, 1'b0, 3'd0, '0));
        stim_rows.push_back(make_row(8'hAC, 1'b0, 1'b0, 3'd0, '0));
        // largest 4-byte lead, code point past 0x10FFFF
        stim_rows.push_back(make_row(8'hF7, 1'b0, 1'b0, 3'd0, '0));
        stim_rows.push_back(make_row(8'hBF, 1'b0, 1'b0, 3'd0, '0));
        stim_rows.push_back(make_row(8'hBF, 1'b0, 1'b0, 3'd0, '0));
        stim_rows.push_back(make_row(8'hBF, 1'b0, 1'b0, 3'd0, '0));
        // ASCII breaks a 4-byte sequence after two continuations
        stim_rows.push_back(make_row(8'hF0, 1'b0, 1'b0, 3'd0, '0));
        stim_rows.push_back(make_row(8'h90, 1'b0, 1'b0, 3'd0, '0));
        stim_rows.push_back(make_row(8'h80, 1'b0, 1'b0, 3'd0, '0));
        stim_rows.push_back(make_row(8'h41, 1'b0, 1'b1, 3'd4,
                                     {REPL_UNIT, REPL_UNIT, REPL_UNIT, 16'h0041}));
        // end marker flushes lead plus one continuation, data byte ignored
        stim_rows.push_back(make_row(8'hE0, 1'b0, 1'b0, 3'd0, '0));
        stim_rows.push_back(make_row(8'hA0, 1'b0, 1'b0, 3'd0, '0));
        stim_rows.push_back(make_row(8'hFF, 1'b1, 1'b1, 3'd2,
                                     {REPL_UNIT, REPL_UNIT, 32'h0}));
        // a lead breaks a lead, then completes
        stim_rows.push_back(make_row(8'hC2, 1'b0, 1'b0, 3'd0, '0));
        stim_rows.push_back(make_row(8'hC2, 1'b0, 1'b1, 3'd1, {REPL_UNIT, 48'h0}));
        stim_rows.push_back(make_row(8'h80, 1'b0, 1'b0, 3'd0, '0));
        directed_count = stim_rows.size();

        append_random_text(directed_count + RANDOM_WORDS);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sender: bursts of back-to-back words with random gaps
        burst_left = 0;
        while (stim_rows.size() != 0) begin
            row = stim_rows.pop_front();
            if (burst_left == 0) begin
                gap = $urandom_range(0, MAX_GAP);
                if (gap != 0) begin
                    @(negedge i_clk);
                    i_in_valid <= 1'b0;
                    i_in_data  <= t_in_word'($urandom);
                    repeat (gap - 1) @(negedge i_clk);
                end
                burst_left = $urandom_range(1, MAX_BURST);
            end
            burst_left--;
            @(negedge i_clk);
            offered_row = row;
            i_in_valid <= 1'b1;
            i_in_data  <= row.word;
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // drain, then keep watching to catch stray units
        while (pending_units.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run: %0d words in (%0d directed, %0d end markers), %0d code units out",
                 words_accepted, directed_count, end_markers, units_checked);
        $display("Run: %0d high surrogates seen, receiver held off %0d cycles once",
                 surrogate_units, HOLD_OFF_CYCLES);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
